// ===== rtl/core/lcd4_pkg.sv =====
// Shared types, constants and the microcode table of the four-bit LCD sequencer.
`timescale 1ns / 1ps

package lcd4_pkg;

  localparam int NUM_W   = 32;
  localparam int DIGITS  = 10;
  localparam int BCD_W   = DIGITS * 4;
  localparam int PC_W    = 5;
  localparam int CNT_W   = 4;
  localparam int BITCNT_W = 6;

  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_INSTR  = 3'd1;
  localparam logic [2:0] CMD_DATA   = 3'd2;
  localparam logic [2:0] CMD_POS    = 3'd3;
  localparam logic [2:0] CMD_NUMBER = 3'd4;

  localparam logic [1:0] WAIT_NONE = 2'd0;
  localparam logic [1:0] WAIT_45US = 2'd1;
  localparam logic [1:0] WAIT_1MS  = 2'd2;
  localparam logic [1:0] WAIT_2MS  = 2'd3;

  localparam logic [7:0] DDRAM_LINE1 = 8'h80;
  localparam logic [7:0] LINE2_OFFSET = 8'd64;
  localparam logic [7:0] ASCII_ZERO  = 8'd48;

  localparam logic [3:0] FUNC_SET_4BIT = 4'b0010;
  localparam logic [7:0] FUNC_SET_2LINE = 8'b0010_1000;
  localparam logic [7:0] DISPLAY_ON    = 8'b0000_1111;
  localparam logic [7:0] CLEAR_CMD     = 8'h01;
  localparam logic [7:0] ENTRY_MODE    = 8'h06;

  localparam logic [PC_W-1:0] PC_IDLE   = 5'd0;
  localparam logic [PC_W-1:0] PC_INIT   = 5'd1;
  localparam logic [PC_W-1:0] PC_BYTE   = 5'd10;
  localparam logic [PC_W-1:0] PC_POS    = 5'd12;
  localparam logic [PC_W-1:0] PC_CONV   = 5'd14;
  localparam logic [PC_W-1:0] PC_SKIPZ  = 5'd15;
  localparam logic [PC_W-1:0] PC_DIG_HI = 5'd16;
  localparam logic [PC_W-1:0] PC_DIG_LO = 5'd17;

  typedef enum logic [1:0] {
    OP_DISPATCH = 2'd0,
    OP_EMIT     = 2'd1,
    OP_CONV     = 2'd2,
    OP_SKIPZ    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SRC_CONST   = 2'd0,
    SRC_BYTE_HI = 2'd1,
    SRC_BYTE_LO = 2'd2,
    SRC_DIGIT   = 2'd3
  } nsrc_t;

  typedef enum logic [1:0] {
    NX_SEQ  = 2'd0,
    NX_IDLE = 2'd1,
    NX_LOOP = 2'd2
  } nxt_t;

  typedef struct packed {
    op_t             op;
    nsrc_t           nsrc;
    logic [3:0]      nib;
    logic            pwr;
    logic [1:0]      settle;
    nxt_t            nxt;
    logic [PC_W-1:0] target;
  } cw_t;

  typedef struct packed {
    logic start;
    logic shift;
  } bcd_ctrl_t;

  typedef struct packed {
    logic       busy;
    logic [3:0] top;
    logic       more;
  } bcd_stat_t;

  typedef struct packed {
    logic       valid;
    logic       rs;
    logic [3:0] nibble;
    logic       pwr;
    logic [1:0] settle;
    logic       last;
  } item_t;

  function automatic cw_t cw_emit(nsrc_t src, logic [3:0] nib, logic pwr,
                                  logic [1:0] settle, nxt_t nxt,
                                  logic [PC_W-1:0] target);
    cw_t w;
    w.op     = OP_EMIT;
    w.nsrc   = src;
    w.nib    = nib;
    w.pwr    = pwr;
    w.settle = settle;
    w.nxt    = nxt;
    w.target = target;
    return w;
  endfunction

  function automatic cw_t cw_ctl(op_t op);
    cw_t w;
    w        = '0;
    w.op     = op;
    w.nsrc   = SRC_CONST;
    w.nxt    = NX_SEQ;
    return w;
  endfunction

  function automatic cw_t lcd4_rom(logic [PC_W-1:0] pc);
    cw_t w;
    unique case (pc)
      5'd0:  w = cw_ctl(OP_DISPATCH);
      5'd1:  w = cw_emit(SRC_CONST, FUNC_SET_4BIT, 1'b1, WAIT_NONE, NX_SEQ, PC_IDLE);
      5'd2:  w = cw_emit(SRC_CONST, FUNC_SET_2LINE[7:4], 1'b0, WAIT_NONE, NX_SEQ, PC_IDLE);
      5'd3:  w = cw_emit(SRC_CONST, FUNC_SET_2LINE[3:0], 1'b0, WAIT_45US, NX_SEQ, PC_IDLE);
      5'd4:  w = cw_emit(SRC_CONST, DISPLAY_ON[7:4], 1'b0, WAIT_NONE, NX_SEQ, PC_IDLE);
      5'd5:  w = cw_emit(SRC_CONST, DISPLAY_ON[3:0], 1'b0, WAIT_45US, NX_SEQ, PC_IDLE);
      5'd6:  w = cw_emit(SRC_CONST, CLEAR_CMD[7:4], 1'b0, WAIT_NONE, NX_SEQ, PC_IDLE);
      5'd7:  w = cw_emit(SRC_CONST, CLEAR_CMD[3:0], 1'b0, WAIT_2MS, NX_SEQ, PC_IDLE);
      5'd8:  w = cw_emit(SRC_CONST, ENTRY_MODE[7:4], 1'b0, WAIT_NONE, NX_SEQ, PC_IDLE);
      5'd9:  w = cw_emit(SRC_CONST, ENTRY_MODE[3:0], 1'b0, WAIT_NONE, NX_IDLE, PC_IDLE);
      5'd10: w = cw_emit(SRC_BYTE_HI, 4'h0, 1'b0, WAIT_NONE, NX_SEQ, PC_IDLE);
      5'd11: w = cw_emit(SRC_BYTE_LO, 4'h0, 1'b0, WAIT_NONE, NX_IDLE, PC_IDLE);
      5'd12: w = cw_emit(SRC_BYTE_HI, 4'h0, 1'b0, WAIT_NONE, NX_SEQ, PC_IDLE);
      5'd13: w = cw_emit(SRC_BYTE_LO, 4'h0, 1'b0, WAIT_1MS, NX_IDLE, PC_IDLE);
      5'd14: w = cw_ctl(OP_CONV);
      5'd15: w = cw_ctl(OP_SKIPZ);
      5'd16: w = cw_emit(SRC_CONST, ASCII_ZERO[7:4], 1'b0, WAIT_NONE, NX_SEQ, PC_IDLE);
      5'd17: w = cw_emit(SRC_DIGIT, 4'h0, 1'b0, WAIT_NONE, NX_LOOP, PC_DIG_HI);
      default: w = cw_ctl(OP_DISPATCH);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/lcd4_bcd.sv =====
// Shift-and-add-3 binary to BCD converter with a most-significant-digit shift out.
`timescale 1ns / 1ps

module lcd4_bcd
  import lcd4_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  bcd_ctrl_t        ctrl,
  input  logic [NUM_W-1:0] value,
  output bcd_stat_t        stat
);

  logic [BCD_W-1:0]    digits_r, digits_nxt;
  logic [NUM_W-1:0]    val_r, val_nxt;
  logic [BITCNT_W-1:0] bits_r, bits_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [BCD_W-1:0]    adj;

  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (digits_r[d*4 +: 4] >= 4'd5) begin
        adj[d*4 +: 4] = digits_r[d*4 +: 4] + 4'd3;
      end else begin
        adj[d*4 +: 4] = digits_r[d*4 +: 4];
      end
    end
  end

  always_comb begin
    digits_nxt = digits_r;
    val_nxt    = val_r;
    bits_nxt   = bits_r;
    cnt_nxt    = cnt_r;
    if (ctrl.start) begin
      digits_nxt = '0;
      val_nxt    = value;
      bits_nxt   = BITCNT_W'(NUM_W);
      cnt_nxt    = CNT_W'(DIGITS);
    end else if (bits_r != '0) begin
      digits_nxt = {adj[BCD_W-2:0], val_r[NUM_W-1]};
      val_nxt    = {val_r[NUM_W-2:0], 1'b0};
      bits_nxt   = bits_r - 1'b1;
    end else if (ctrl.shift) begin
      digits_nxt = {digits_r[BCD_W-5:0], 4'h0};
      cnt_nxt    = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
    end else begin
      bits_r <= bits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digits_r <= digits_nxt;
    val_r    <= val_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign stat.busy = (bits_r != '0);
  assign stat.top  = digits_r[BCD_W-1 -: 4];
  assign stat.more = (cnt_r > CNT_W'(1));

endmodule

// ===== rtl/core/lcd4_seq.sv =====
// Microcode sequencer: step counter, request capture and nibble selection.
`timescale 1ns / 1ps

module lcd4_seq
  import lcd4_pkg::*;
#(
  parameter int COLUMNS_PER_LINE = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_command,
  input  logic [7:0] in_byte_value,
  input  logic [7:0] in_line_number,
  input  logic [7:0] in_column_number,
  output logic       idle,
  input  logic       out_ready,
  input  bcd_stat_t  bstat,
  output bcd_ctrl_t  bctrl,
  output item_t      item
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic            rs_r, rs_nxt;
  cw_t             cw;
  logic            accept;
  logic            emit_go;
  logic            col_ok;
  logic [7:0]      pos_addr;

  assign cw     = lcd4_rom(pc_r);
  assign idle   = (cw.op == OP_DISPATCH);
  assign accept = idle && in_valid;
  assign emit_go = (cw.op == OP_EMIT) && out_ready;

  always_comb begin
    col_ok   = (in_column_number >= 8'd1) &&
               (in_column_number <= 8'(COLUMNS_PER_LINE));
    pos_addr = DDRAM_LINE1;
    if (col_ok && in_line_number == 8'd1) begin
      pos_addr = DDRAM_LINE1 + in_column_number - 8'd1;
    end else if (col_ok && in_line_number == 8'd2) begin
      pos_addr = DDRAM_LINE1 + LINE2_OFFSET + in_column_number - 8'd1;
    end
  end

  always_comb begin
    pc_nxt      = pc_r;
    byte_nxt    = byte_r;
    rs_nxt      = rs_r;
    bctrl.start = 1'b0;
    bctrl.shift = 1'b0;
    unique case (cw.op)
      OP_DISPATCH: begin
        if (accept) begin
          rs_nxt = (in_command == CMD_DATA) || (in_command == CMD_NUMBER);
          unique case (in_command)
            CMD_INIT: pc_nxt = PC_INIT;
            CMD_INSTR, CMD_DATA: begin
              pc_nxt   = PC_BYTE;
              byte_nxt = in_byte_value;
            end
            CMD_POS: begin
              pc_nxt   = PC_POS;
              byte_nxt = pos_addr;
            end
            CMD_NUMBER: begin
              pc_nxt      = PC_CONV;
              bctrl.start = 1'b1;
            end
            default: pc_nxt = PC_IDLE;
          endcase
        end
      end
      OP_CONV: begin
        if (!bstat.busy) begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      OP_SKIPZ: begin
        if (bstat.top == 4'h0 && bstat.more) begin
          bctrl.shift = 1'b1;
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      OP_EMIT: begin
        if (emit_go) begin
          unique case (cw.nxt)
            NX_SEQ:  pc_nxt = pc_r + 1'b1;
            NX_LOOP: begin
              if (bstat.more) begin
                pc_nxt      = cw.target;
                bctrl.shift = 1'b1;
              end else begin
                pc_nxt = PC_IDLE;
              end
            end
            default: pc_nxt = PC_IDLE;
          endcase
        end
      end
      default: pc_nxt = PC_IDLE;
    endcase
  end

  always_comb begin
    item.valid  = emit_go;
    item.rs     = rs_r;
    item.pwr    = cw.pwr;
    item.settle = cw.settle;
    item.last   = (cw.nxt == NX_IDLE) || (cw.nxt == NX_LOOP && !bstat.more);
    unique case (cw.nsrc)
      SRC_CONST:   item.nibble = cw.nib;
      SRC_BYTE_HI: item.nibble = byte_r[7:4];
      SRC_BYTE_LO: item.nibble = byte_r[3:0];
      SRC_DIGIT:   item.nibble = bstat.top;
      default:     item.nibble = cw.nib;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    rs_r   <= rs_nxt;
  end

endmodule

// ===== rtl/core/char_lcd_four_bit_command_sequencer.sv =====
// Top level of the four-bit character LCD command sequencer.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | command, byte, number, line, column
//   out_    | output    | out_valid/out_stall | rs, nibble, waits, last flag
//
// One request at a time; in_stall is high from acceptance until its last nibble
// has been moved into the output register.
// Byte and position requests send two nibbles, init nine; a number request passes through
// dispatch, the bit-serial BCD step, a skip step that drops leading zeros (up to 9),
// then two nibbles per digit. out_stall holds an emit step while the output register is full.
// Reset is synchronous and clears the step counter, the BCD bit counter and the output valid flag.
`timescale 1ns / 1ps

module char_lcd_four_bit_command_sequencer
  import lcd4_pkg::*;
#(
  parameter int COLUMNS_PER_LINE = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_byte_value,
  input  logic [31:0] in_number_value,
  input  logic [7:0]  in_line_number,
  input  logic [7:0]  in_column_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_register_select,
  output logic [3:0]  out_nibble,
  output logic        out_power_up_wait,
  output logic [1:0]  out_settle_wait,
  output logic        out_last_transfer
);

  logic      idle;
  logic      out_ready;
  bcd_ctrl_t bctrl;
  bcd_stat_t bstat;
  item_t     item;
  logic      out_valid_r, out_valid_nxt;
  item_t     out_item_r;

  assign in_stall  = !idle;
  assign out_ready = !out_valid_r || !out_stall;

  lcd4_seq #(
    .COLUMNS_PER_LINE(COLUMNS_PER_LINE)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_command      (in_command),
    .in_byte_value   (in_byte_value),
    .in_line_number  (in_line_number),
    .in_column_number(in_column_number),
    .idle            (idle),
    .out_ready       (out_ready),
    .bstat           (bstat),
    .bctrl           (bctrl),
    .item            (item)
  );

  lcd4_bcd u_bcd (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (bctrl),
    .value(in_number_value),
    .stat (bstat)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (item.valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid) begin
      out_item_r <= item;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_register_select = out_item_r.rs;
  assign out_nibble          = out_item_r.nibble;
  assign out_power_up_wait   = out_item_r.pwr;
  assign out_settle_wait     = out_item_r.settle;
  assign out_last_transfer   = out_item_r.last;

endmodule

// ===== rtl/core/lcd4_chk.sv =====
// Port-level checker for the LCD sequencer and its bind to the top level.
`timescale 1ns / 1ps

module lcd4_chk
  import lcd4_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [2:0] in_command,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_register_select,
  input logic [3:0] out_nibble,
  input logic       out_power_up_wait,
  input logic       out_last_transfer
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command <= CMD_NUMBER |=> in_stall)
    else $error("input not held off after a request was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_nibble))
    else $error("stalled transfer changed");

  a_power_up_nibble: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_power_up_wait |-> out_nibble == FUNC_SET_4BIT && !out_register_select)
    else $error("power-up wait on a transfer other than the 4-bit switch");

  a_idle_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid || out_last_transfer)
    else $error("ready for input while a request is unfinished");

endmodule

bind char_lcd_four_bit_command_sequencer lcd4_chk u_lcd4_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_command         (in_command),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_register_select(out_register_select),
  .out_nibble         (out_nibble),
  .out_power_up_wait  (out_power_up_wait),
  .out_last_transfer  (out_last_transfer)
);

// ===== tb/char_lcd_four_bit_command_sequencer_test.sv =====
// Self-checking testbench: LCD requests in, predicted nibble transfers compared field by field.
`timescale 1ns / 1ps

module char_lcd_four_bit_command_sequencer_test;
  import lcd4_pkg::*;

  localparam int COLUMNS_PER_LINE = 16;
  localparam int HOLD_AT = 270;
  localparam int HOLD_CYCLES = 400;

  localparam logic [3:0] FUNCTION_SET_NIBBLE = 4'h2;
  localparam logic [7:0] FUNCTION_SET_BYTE   = 8'h28;
  localparam logic [7:0] DISPLAY_ON_BYTE     = 8'h0F;
  localparam logic [7:0] CLEAR_BYTE          = 8'h01;
  localparam logic [7:0] ENTRY_MODE_BYTE     = 8'h06;
  localparam logic [7:0] HOME_ADDRESS        = 8'h80;
  localparam logic [7:0] SECOND_LINE_OFFSET  = 8'h40;

  typedef struct {
    logic [2:0]  command;
    logic [7:0]  byte_value;
    logic [31:0] number_value;
    logic [7:0]  line_number;
    logic [7:0]  column_number;
  } lcd_request_t;

  typedef struct {
    logic       register_select;
    logic [3:0] nibble;
    logic       power_up_wait;
    logic [1:0] settle_wait;
    logic       last_transfer;
  } lcd_xfer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_command = '0;
  logic [7:0]  in_byte_value = '0;
  logic [31:0] in_number_value = '0;
  logic [7:0]  in_line_number = '0;
  logic [7:0]  in_column_number = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_register_select;
  logic [3:0]  out_nibble;
  logic        out_power_up_wait;
  logic [1:0]  out_settle_wait;
  logic        out_last_transfer;

  lcd_request_t request_queue[$];
  lcd_xfer_t    expected_xfers[$];
  lcd_request_t offered;
  lcd_xfer_t    next_xfer;
  int unsigned  send_idle_pct = 25;
  int unsigned  recv_idle_pct = 49;
  int unsigned  accepted_requests = 0;
  int unsigned  hold_left = 0;
  logic         hold_fired = 1'b0;
  int           mismatches = 0;

  char_lcd_four_bit_command_sequencer #(
    .COLUMNS_PER_LINE(COLUMNS_PER_LINE)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_byte_value      (in_byte_value),
    .in_number_value    (in_number_value),
    .in_line_number     (in_line_number),
    .in_column_number   (in_column_number),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_register_select(out_register_select),
    .out_nibble         (out_nibble),
    .out_power_up_wait  (out_power_up_wait),
    .out_settle_wait    (out_settle_wait),
    .out_last_transfer  (out_last_transfer)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic push_xfer(logic rs, logic [3:0] nib, logic pwr, logic [1:0] settle);
    lcd_xfer_t x;
    x.register_select = rs;
    x.nibble          = nib;
    x.power_up_wait   = pwr;
    x.settle_wait     = settle;
    x.last_transfer   = 1'b0;
    expected_xfers.push_back(x);
  endtask

  task automatic push_byte(logic rs, logic [7:0] data_byte, logic [1:0] settle);
    push_xfer(rs, data_byte[7:4], 1'b0, WAIT_NONE);
    push_xfer(rs, data_byte[3:0], 1'b0, settle);
  endtask

  task automatic expand_request(lcd_request_t r);
    int unsigned first;
    int unsigned value;
    logic [7:0]  address;
    logic [3:0]  digits[$];
    lcd_xfer_t   tail;
    first = expected_xfers.size();
    case (r.command)
      CMD_INIT: begin
        push_xfer(1'b0, FUNCTION_SET_NIBBLE, 1'b1, WAIT_NONE);
        push_byte(1'b0, FUNCTION_SET_BYTE, WAIT_45US);
        push_byte(1'b0, DISPLAY_ON_BYTE, WAIT_45US);
        push_byte(1'b0, CLEAR_BYTE, WAIT_2MS);
        push_byte(1'b0, ENTRY_MODE_BYTE, WAIT_NONE);
      end
      CMD_INSTR: push_byte(1'b0, r.byte_value, WAIT_NONE);
      CMD_DATA: push_byte(1'b1, r.byte_value, WAIT_NONE);
      CMD_POS: begin
        address = HOME_ADDRESS;
        if (r.column_number >= 8'd1 && r.column_number <= 8'(COLUMNS_PER_LINE)) begin
          if (r.line_number == 8'd1) begin
            address = HOME_ADDRESS + r.column_number - 8'd1;
          end else if (r.line_number == 8'd2) begin
            address = HOME_ADDRESS + SECOND_LINE_OFFSET + r.column_number - 8'd1;
          end
        end
        push_byte(1'b0, address, WAIT_1MS);
      end
      CMD_NUMBER: begin
        value = r.number_value;
        do begin
          digits.push_front(4'(value % 10));
          value = value / 10;
        end while (value != 0);
        foreach (digits[i]) push_byte(1'b1, {4'h3, digits[i]}, WAIT_NONE);
      end
      default: ;
    endcase
    if (expected_xfers.size() > first) begin
      tail = expected_xfers.pop_back();
      tail.last_transfer = 1'b1;
      expected_xfers.push_back(tail);
    end
  endtask

  function automatic void add_request(logic [2:0] cmd, logic [7:0] b, logic [31:0] num,
                                      logic [7:0] line, logic [7:0] col);
    lcd_request_t r;
    r.command       = cmd;
    r.byte_value    = b;
    r.number_value  = num;
    r.line_number   = line;
    r.column_number = col;
    request_queue.push_back(r);
  endfunction

  function automatic lcd_request_t random_request();
    lcd_request_t r;
    int unsigned  pick;
    int unsigned  power;
    r.command       = CMD_INIT;
    r.byte_value    = 8'($urandom);
    r.number_value  = $urandom;
    r.line_number   = 8'($urandom);
    r.column_number = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      r.command = CMD_INIT;
    end else if (pick < 20) begin
      r.command = CMD_INSTR;
    end else if (pick < 40) begin
      r.command = CMD_DATA;
    end else if (pick < 62) begin
      r.command = CMD_POS;
      pick = $urandom_range(0, 9);
      if (pick < 8) r.line_number = 8'($urandom_range(1, 2));
      else if (pick == 8) r.line_number = 8'($urandom_range(0, 3));
      pick = $urandom_range(0, 9);
      if (pick < 7) r.column_number = 8'($urandom_range(1, COLUMNS_PER_LINE));
      else if (pick < 9) r.column_number = 8'($urandom_range(0, COLUMNS_PER_LINE + 2));
    end else if (pick < 92) begin
      r.command = CMD_NUMBER;
      pick = $urandom_range(0, 11);
      if (pick < 3) begin
        r.number_value = $urandom_range(0, 999);
      end else if (pick < 6) begin
        power = 1;
        repeat ($urandom_range(0, 9)) power = power * 10;
        r.number_value = power + $urandom_range(0, 2) - 1;
      end else if (pick < 8) begin
        r.number_value = $urandom_range(1_000_000_000, 32'hFFFF_FFFF);
      end
    end else begin
      r.command = 3'($urandom_range(CMD_NUMBER + 1, 7));
    end
    return r;
  endfunction

  function automatic void add_random(int unsigned count);
    lcd_request_t r;
    int unsigned  real_items;
    real_items = 0;
    while (real_items < count) begin
      r = random_request();
      request_queue.push_back(r);
      if (r.command <= CMD_NUMBER) real_items++;
    end
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      mismatches++;
    end
  endtask

  // driver: present a new request once the current one has been accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expand_request(offered);
        accepted_requests <= accepted_requests + 1;
      end
      if (!in_valid || !in_stall) begin
        if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered = request_queue.pop_front();
          in_valid         <= 1'b1;
          in_command       <= offered.command;
          in_byte_value    <= offered.byte_value;
          in_number_value  <= offered.number_value;
          in_line_number   <= offered.line_number;
          in_column_number <= offered.column_number;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      hold_fired <= 1'b0;
    end else if (!hold_fired && accepted_requests == HOLD_AT) begin
      hold_left  <= HOLD_CYCLES;
      hold_fired <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_xfers.size() == 0) begin
          $error("unexpected transfer: rs %0h nibble %0h", out_register_select, out_nibble);
          mismatches++;
        end else begin
          next_xfer = expected_xfers.pop_front();
          check_field("register_select", next_xfer.register_select, out_register_select);
          check_field("nibble", next_xfer.nibble, out_nibble);
          check_field("power_up_wait", next_xfer.power_up_wait, out_power_up_wait);
          check_field("settle_wait", next_xfer.settle_wait, out_settle_wait);
          check_field("last_transfer", next_xfer.last_transfer, out_last_transfer);
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin
    add_request(CMD_INIT, 8'h00, 32'd0, 8'd0, 8'd0);
    add_request(CMD_INSTR, 8'h00, 32'd0, 8'd0, 8'd0);
    add_request(CMD_INSTR, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    add_request(CMD_DATA, 8'h00, 32'd0, 8'd0, 8'd0);
    add_request(CMD_DATA, 8'hFF, 32'd0, 8'd0, 8'd0);
    add_request(CMD_DATA, 8'hA5, 32'd0, 8'd0, 8'd0);
    add_request(CMD_POS, 8'h00, 32'd0, 8'd1, 8'd1);
    add_request(CMD_POS, 8'h00, 32'd0, 8'd1, 8'(COLUMNS_PER_LINE));
    add_request(CMD_POS, 8'h00, 32'd0, 8'd2, 8'd1);
    add_request(CMD_POS, 8'h00, 32'd0, 8'd2, 8'(COLUMNS_PER_LINE));
    add_request(CMD_POS, 8'h00, 32'd0, 8'd0, 8'd5);
    add_request(CMD_POS, 8'h00, 32'd0, 8'd3, 8'd5);
    add_request(CMD_POS, 8'h00, 32'd0, 8'd1, 8'd0);
    add_request(CMD_POS, 8'h00, 32'd0, 8'd1, 8'(COLUMNS_PER_LINE + 1));
    add_request(CMD_POS, 8'h00, 32'd0, 8'd2, 8'hFF);
    add_request(CMD_POS, 8'h00, 32'd0, 8'hFF, 8'hFF);
    add_request(CMD_NUMBER, 8'h00, 32'd0, 8'd0, 8'd0);
    add_request(CMD_NUMBER, 8'h00, 32'd9, 8'd0, 8'd0);
    add_request(CMD_NUMBER, 8'h00, 32'd10, 8'd0, 8'd0);
    add_request(CMD_NUMBER, 8'h00, 32'hFFFF_FFFF, 8'd0, 8'd0);
    add_request(CMD_NUMBER, 8'h00, 32'd1_000_000_000, 8'd0, 8'd0);
    add_request(CMD_NUMBER, 8'h00, 32'd999_999_999, 8'd0, 8'd0);
    add_request(3'd5, 8'h00, 32'd0, 8'd1, 8'd1);
    add_request(3'd7, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    add_random(95);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (request_queue.size() != 0) @(posedge clk);
    send_idle_pct = 49;
    recv_idle_pct = 25;
    add_random(95);
    while (request_queue.size() != 0) @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(95);
    while (request_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_xfers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_xfers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
